/* hdl/palmdoc_lz77_decompressor_unit_defines.svh */
// assertion macros used by the checker file
// both expect clk in scope, and PDLZ_ASSERT also expects rst_n
`ifndef PALMDOC_LZ77_DECOMPRESSOR_UNIT_DEFINES_SVH
`define PALMDOC_LZ77_DECOMPRESSOR_UNIT_DEFINES_SVH

// checked outside reset
`define PDLZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PDLZ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pdlz_pkg.sv */
// ----------------------------------------------------------------------------
// pdlz_pkg
// Types, codes and helpers of the PalmDOC LZ77 decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package pdlz_pkg;

  // history window
  localparam int WINDOW_DEPTH = 2048;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int DIST_W       = 11;
  localparam int COUNT_W      = 14;
  localparam int LEN_W        = 4;
  localparam int HELD_W       = 6;

  // command queue between front and back end
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [COUNT_W-1:0] RECORD_SIZE_RST = 14'd4096;

  // token classes
  localparam logic [7:0] TOK_RAW_LO   = 8'h01;
  localparam logic [7:0] TOK_RAW_HI   = 8'h08;
  localparam logic [7:0] TOK_PAIR_LO  = 8'h80;
  localparam logic [7:0] TOK_PAIR_HI  = 8'hBF;
  localparam logic [7:0] TOK_SPACE_LO = 8'hC0;
  localparam logic [7:0] TOK_SPACE_HI = 8'hFF;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] LOW7_MASK    = 8'h7F;
  localparam logic [LEN_W-1:0] COPY_LEN_BASE = 4'd3;

  typedef logic [HIST_AW-1:0] hist_addr_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIST = 2'd1,
    ST_SIZE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PM_IDLE = 2'd0,
    PM_RAW  = 2'd1,
    PM_PAIR = 2'd2
  } parse_mode_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_SPACE = 2'd2,
    CMD_COPY  = 2'd3
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BE_IDLE   = 2'd0,
    BE_SPACE2 = 2'd1,
    BE_COPY   = 2'd2
  } be_state_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       record_start;
  } pdlz_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last_of_run;
  } pdlz_out_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic              restart;
    logic [7:0]        byte_val;
    logic [DIST_W-1:0] copy_dist;
    logic [LEN_W-1:0]  len;
  } pdlz_cmd_t;

  // next write position, wrapping at the window depth
  function automatic hist_addr_t hist_inc(input hist_addr_t a);
    hist_addr_t r;
    if (a == hist_addr_t'(WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = a + hist_addr_t'(1);
    end
    return r;
  endfunction

  // position d bytes behind a, modulo the window depth
  function automatic hist_addr_t hist_back(input hist_addr_t a,
                                           input logic [DIST_W-1:0] d);
    logic [HIST_AW:0] w;
    logic [HIST_AW:0] dx;
    logic [HIST_AW:0] r;
    w  = {1'b0, a};
    dx = {{(HIST_AW + 1 - DIST_W){1'b0}}, d};
    if (w >= dx) begin
      r = w - dx;
    end else begin
      r = w + (HIST_AW + 1)'(WINDOW_DEPTH) - dx;
    end
    return r[HIST_AW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/pdlz_ram.sv */
// ----------------------------------------------------------------------------
// pdlz_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/pdlz_front.sv */
// ----------------------------------------------------------------------------
// pdlz_front
// Token parser: takes compressed bytes and turns them into back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlz_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdlz_pkg::pdlz_in_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output pdlz_pkg::pdlz_cmd_t q_data
);

  import pdlz_pkg::*;

  parse_mode_t       mode_r, mode_nxt, mode_b;
  logic [LEN_W-1:0]  raw_r, raw_nxt, raw_b, raw_dec;
  logic [HELD_W-1:0] held_r, held_nxt, held_b;
  logic              acc;
  logic [7:0]        b;
  pdlz_cmd_t         cmd;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign b        = in_data.code_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PM_IDLE;
      raw_r  <= '0;
      held_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      raw_r  <= raw_nxt;
      held_r <= held_nxt;
    end
  end

  always_comb begin
    // a record start drops any pending raw run or pair
    mode_b  = in_data.record_start ? PM_IDLE : mode_r;
    raw_b   = in_data.record_start ? '0 : raw_r;
    held_b  = in_data.record_start ? '0 : held_r;
    raw_dec = raw_b - LEN_W'(1);

    mode_nxt = mode_b;
    raw_nxt  = raw_b;
    held_nxt = held_b;

    cmd          = '0;
    cmd.kind     = CMD_NONE;
    cmd.restart  = in_data.record_start;
    cmd.byte_val = b;

    unique case (mode_b)
      PM_RAW: begin
        cmd.kind = CMD_LIT;
        raw_nxt  = raw_dec;
        mode_nxt = (raw_dec == '0) ? PM_IDLE : PM_RAW;
      end
      PM_PAIR: begin
        cmd.kind      = CMD_COPY;
        cmd.copy_dist = {held_b, b[7:3]};
        cmd.len       = {1'b0, b[2:0]} + COPY_LEN_BASE;
        mode_nxt      = PM_IDLE;
        held_nxt      = '0;
      end
      PM_IDLE: begin
        unique case (b) inside
          [TOK_RAW_LO:TOK_RAW_HI]: begin
            raw_nxt  = b[LEN_W-1:0];
            mode_nxt = PM_RAW;
          end
          [TOK_PAIR_LO:TOK_PAIR_HI]: begin
            held_nxt = b[HELD_W-1:0];
            mode_nxt = PM_PAIR;
          end
          [TOK_SPACE_LO:TOK_SPACE_HI]: begin
            cmd.kind     = CMD_SPACE;
            cmd.byte_val = b & LOW7_MASK;
          end
          default: begin
            cmd.kind = CMD_LIT;
          end
        endcase
      end
      default: begin
        mode_nxt = PM_IDLE;
      end
    endcase
  end

  // a restart with no output still goes down to clear the back-end counters
  assign q_push = acc && ((cmd.kind != CMD_NONE) || cmd.restart);
  assign q_data = cmd;

endmodule

`default_nettype wire

/* hdl/pdlz_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// pdlz_cmd_fifo
// Short command queue that decouples the parser from the byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlz_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pdlz_pkg::pdlz_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output pdlz_pkg::pdlz_cmd_t head_data
);

  import pdlz_pkg::*;

  pdlz_cmd_t          entries_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   count_r;
  logic               do_push, do_pop;

  assign full       = (count_r == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (CMDQ_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (CMDQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/pdlz_back.sv */
// ----------------------------------------------------------------------------
// pdlz_back
// Byte engine: runs commands against the history window, counts the record
// and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdlz_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pdlz_pkg::COUNT_W-1:0] record_size,
  input  logic                        q_valid,
  input  pdlz_pkg::pdlz_cmd_t         q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pdlz_pkg::pdlz_out_t         out_data
);

  import pdlz_pkg::*;

  be_state_t          state_r, state_nxt;
  hist_addr_t         widx_r, widx_nxt, widx_base, widx_after;
  logic [COUNT_W-1:0] count_r, count_nxt, cnt_base;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [7:0]         cur_byte_r, cur_byte_nxt;
  logic               byp_r, byp_nxt;
  logic [7:0]         byp_byte_r, byp_byte_nxt;
  logic               out_valid_r, out_valid_nxt;
  pdlz_out_t          out_data_r, out_data_nxt;

  logic               can_emit, restart, em_ok, dist_bad;
  logic               emit, em_last, em_dist_err;
  logic [7:0]         em_byte, copy_byte;
  logic               ram_we, ram_re;
  hist_addr_t         ram_raddr;
  logic [7:0]         ram_rdata;

  pdlz_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx_base),
    .wdata (em_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign can_emit  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BE_IDLE;
      widx_r      <= '0;
      count_r     <= '0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      widx_r      <= widx_nxt;
      count_r     <= count_nxt;
      byp_r       <= byp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    len_r      <= len_nxt;
    cur_byte_r <= cur_byte_nxt;
    byp_byte_r <= byp_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    dist_nxt     = dist_r;
    len_nxt      = len_r;
    cur_byte_nxt = cur_byte_r;
    byp_nxt      = byp_r;
    byp_byte_nxt = byp_byte_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    em_byte      = '0;
    em_last      = 1'b0;
    em_dist_err  = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    restart    = (state_r == BE_IDLE) && q_valid && can_emit && q_data.restart;
    widx_base  = restart ? '0 : widx_r;
    cnt_base   = restart ? '0 : count_r;
    widx_nxt   = widx_base;
    count_nxt  = cnt_base;
    em_ok      = (cnt_base < record_size);
    widx_after = em_ok ? hist_inc(widx_base) : widx_base;
    // a byte written in the cycle its read was issued comes from the bypass
    copy_byte  = byp_r ? byp_byte_r : ram_rdata;
    dist_bad   = (q_data.copy_dist == '0)
              || ({{(COUNT_W - DIST_W){1'b0}}, q_data.copy_dist} > cnt_base)
              || ({{(HIST_AW + 1 - DIST_W){1'b0}}, q_data.copy_dist}
                  >= (HIST_AW + 1)'(WINDOW_DEPTH));

    unique case (state_r)
      BE_IDLE: begin
        if (q_valid && can_emit) begin
          q_pop = 1'b1;
          unique case (q_data.kind)
            CMD_LIT: begin
              emit    = 1'b1;
              em_byte = q_data.byte_val;
              em_last = 1'b1;
            end
            CMD_SPACE: begin
              emit         = 1'b1;
              em_byte      = SPACE_CHAR;
              cur_byte_nxt = q_data.byte_val;
              state_nxt    = BE_SPACE2;
            end
            CMD_COPY: begin
              if (dist_bad) begin
                emit        = 1'b1;
                em_dist_err = 1'b1;
                em_last     = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = hist_back(widx_base, q_data.copy_dist);
                byp_nxt   = 1'b0;
                dist_nxt  = q_data.copy_dist;
                len_nxt   = q_data.len;
                state_nxt = BE_COPY;
              end
            end
            CMD_NONE: begin
              // counters already cleared through restart
            end
          endcase
        end
      end
      BE_SPACE2: begin
        if (can_emit) begin
          emit      = 1'b1;
          em_byte   = cur_byte_r;
          em_last   = 1'b1;
          state_nxt = BE_IDLE;
        end
      end
      BE_COPY: begin
        if (can_emit) begin
          emit    = 1'b1;
          em_byte = copy_byte;
          em_last = (len_r == LEN_W'(1));
          if (len_r == LEN_W'(1)) begin
            state_nxt = BE_IDLE;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = hist_back(widx_after, dist_r);
            byp_nxt      = em_ok && (ram_raddr == widx_r);
            byp_byte_nxt = copy_byte;
            len_nxt      = len_r - LEN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = BE_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (em_dist_err) begin
        out_data_nxt = '{out_byte: 8'h00, status: ST_DIST, last_of_run: 1'b1};
      end else if (em_ok) begin
        ram_we       = 1'b1;
        widx_nxt     = widx_after;
        count_nxt    = cnt_base + COUNT_W'(1);
        out_data_nxt = '{out_byte: em_byte, status: ST_OK, last_of_run: em_last};
      end else begin
        out_data_nxt = '{out_byte: 8'h00, status: ST_SIZE, last_of_run: em_last};
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/palmdoc_lz77_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// palmdoc_lz77_decompressor_unit
// PalmDOC LZ77 decoder: compressed bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload      | notes
//  --------+-----+--------------+-------------------------------------------
//  in_     | in  | pdlz_in_t    | one compressed byte, record start flag
//  out_    | out | pdlz_out_t   | one decoded byte, status, last of run
//  cfg_    | in  | 14-bit value | record size, write while idle
//
//  the back end gives at most one result per cycle unless stalled: a literal
//  gives one result, a space pair two, a copy of length n gives n (the
//  history RAM read is registered and issued one byte ahead), an invalid
//  copy one; raw count tokens and pair heads are absorbed in the parser;
//  a four-entry command queue lets the parser keep taking bytes while a
//  copy runs or out_ready is low; out_ready low with a result pending
//  freezes the byte engine; synchronous active-low reset; the history is
//  not cleared, reads are limited to bytes written in the current record
`default_nettype none

module palmdoc_lz77_decompressor_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pdlz_pkg::pdlz_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pdlz_pkg::pdlz_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pdlz_pkg::COUNT_W-1:0] cfg_data
);

  import pdlz_pkg::*;

  logic [COUNT_W-1:0] record_size_r;
  logic               q_full, q_push, q_pop, q_valid;
  pdlz_cmd_t          q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_size_r <= RECORD_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      record_size_r <= cfg_data;
    end
  end

  pdlz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  pdlz_cmd_fifo u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  pdlz_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .record_size (record_size_r),
    .q_valid     (q_valid),
    .q_data      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

/* hdl/pdlz_checker.sv */
// ----------------------------------------------------------------------------
// pdlz_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "palmdoc_lz77_decompressor_unit_defines.svh"

module pdlz_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input pdlz_pkg::pdlz_out_t out_data
);

  import pdlz_pkg::*;

  `PDLZ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
  `PDLZ_ASSERT_ALWAYS(a_out_reset, !rst_n |=> !out_valid, "result pending after reset")
  `PDLZ_ASSERT(a_err_zero, out_valid && (out_data.status != ST_OK) |-> (out_data.out_byte == 8'h00), "error item with nonzero byte")
  `PDLZ_ASSERT(a_dist_last, out_valid && (out_data.status == ST_DIST) |-> out_data.last_of_run, "distance error not last of run")

endmodule

bind palmdoc_lz77_decompressor_unit pdlz_checker u_pdlz_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives compressed PalmDOC bytes into the LZ77 decoder and checks every
// decoded byte, status and end-of-run flag against a predictor in the bench.
// Covers hand-picked tokens, tight record sizes, a record long enough to wrap
// the history, then random records. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pdlz_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pdlz_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pdlz_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  // decoder state as predicted
  logic [7:0] hist_mem [WINDOW_DEPTH];
  logic [HIST_AW-1:0] wr_pos = '0;
  logic [COUNT_W-1:0] out_count = '0;
  parse_mode_t mode = PM_IDLE;
  logic [LEN_W-1:0] raw_left = '0;
  logic [HELD_W-1:0] held_bits = '0;
  logic [COUNT_W-1:0] rec_size = RECORD_SIZE_RST;

  // decoded results still to arrive, oldest first
  pdlz_out_t decoded_q[$];
  pdlz_out_t pend;
  bit pend_ok = 1'b0;

  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always #4 clk = ~clk;

  palmdoc_lz77_decompressor_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void add_expected(input pdlz_out_t r);
    decoded_q.insert(decoded_q.size(), r);
  endfunction

  // one result is held back so the last of a run can be flagged
  function automatic void queue_result(input logic [7:0] v, input status_t st);
    if (pend_ok) begin
      add_expected(pend);
    end
    pend = '{out_byte: v, status: st, last_of_run: 1'b0};
    pend_ok = 1'b1;
  endfunction

  function automatic void flush_run();
    if (pend_ok) begin
      pend.last_of_run = 1'b1;
      add_expected(pend);
      pend_ok = 1'b0;
    end
  endfunction

  function automatic void emit_byte(input logic [7:0] v);
    if (out_count < rec_size) begin
      hist_mem[wr_pos] = v;
      wr_pos = wr_pos + 1'b1;
      out_count = out_count + 1'b1;
      queue_result(v, ST_OK);
    end else begin
      queue_result(8'h00, ST_SIZE);
    end
  endfunction

  function automatic void decode_code_byte(input pdlz_in_t req);
    logic [7:0] b;
    logic [DIST_W-1:0] cp_dist;
    logic [LEN_W-1:0] len;
    b = req.code_byte;
    if (req.record_start) begin
      wr_pos = '0;
      out_count = '0;
      mode = PM_IDLE;
      raw_left = '0;
      held_bits = '0;
    end
    if (mode == PM_RAW) begin
      emit_byte(b);
      raw_left = raw_left - 1'b1;
      if (raw_left == '0) begin
        mode = PM_IDLE;
      end
    end else if (mode == PM_PAIR) begin
      cp_dist = {held_bits, b[7:3]};
      len = LEN_W'(b[2:0]) + COPY_LEN_BASE;
      mode = PM_IDLE;
      held_bits = '0;
      if (cp_dist == '0 || COUNT_W'(cp_dist) > out_count) begin
        queue_result(8'h00, ST_DIST);
      end else begin
        // position moves only when a byte is stored
        for (int i = 0; i < int'(len); i++) begin
          emit_byte(hist_mem[HIST_AW'(wr_pos - cp_dist)]);
        end
      end
    end else if (b >= TOK_RAW_LO && b <= TOK_RAW_HI) begin
      raw_left = LEN_W'(b);
      mode = PM_RAW;
    end else if (b >= TOK_PAIR_LO && b <= TOK_PAIR_HI) begin
      held_bits = b[HELD_W-1:0];
      mode = PM_PAIR;
    end else if (b >= TOK_SPACE_LO) begin
      emit_byte(SPACE_CHAR);
      emit_byte(b & LOW7_MASK);
    end else begin
      emit_byte(b);
    end
    flush_run();
  endfunction

  task automatic send_code(input logic [7:0] code, input logic start);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = '{code_byte: code, record_start: start};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    decode_code_byte(in_data);
    sent_cnt++;
  endtask

  task automatic send_pair(input logic [DIST_W-1:0] cp_dist, input logic [2:0] len_code,
                           input logic start);
    send_code(TOK_PAIR_LO | {2'b00, cp_dist[10:5]}, start);
    send_code({cp_dist[4:0], len_code}, 1'b0);
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    // a raw count or pair head that starts a record may still sit in the command queue
    repeat (32) @(posedge clk);
  endtask

  task automatic write_record_size(input logic [COUNT_W-1:0] size);
    wait_all_results();
    @(negedge clk);
    cfg_data = size;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    rec_size = size;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one well-formed token with random content, or now and then a stray byte
  task automatic send_random_token(input int unsigned copy_pct, input bit long_copy,
                                   input bit strays, input logic start);
    int unsigned r;
    int unsigned n;
    int unsigned lim;
    logic [DIST_W-1:0] d;
    logic [2:0] lc;
    r = $urandom_range(0, 99);
    lim = (out_count > 14'd2047) ? 2047 : int'(out_count);
    if (strays && r < 4) begin
      send_code(8'($urandom), start | 1'($urandom));
    end else if (r < copy_pct) begin
      if (lim == 0 || $urandom_range(0, 9) == 0) begin
        if (lim == 2047 || $urandom_range(0, 1) == 0) begin
          d = '0;
        end else begin
          d = DIST_W'($urandom_range(lim + 1, 2047));
        end
      end else if ($urandom_range(0, 1) == 0) begin
        d = DIST_W'($urandom_range(1, (lim < 16) ? lim : 16));
      end else begin
        d = DIST_W'($urandom_range(1, lim));
      end
      lc = (long_copy && $urandom_range(0, 7) != 0) ? 3'd7 : 3'($urandom);
      send_pair(d, lc, start);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          n = $urandom_range(8, 127);
          send_code((n == 8) ? 8'h00 : 8'(n), start);
        end
        1: begin
          n = $urandom_range(1, 8);
          send_code(8'(n), start);
          repeat (n) send_code(8'($urandom), 1'b0);
        end
        default: begin
          send_code(8'($urandom_range(192, 255)), start);
        end
      endcase
    end
  endtask

  task automatic test_directed();
    send_code(8'h00, 1'b1);
    send_code(8'h09, 1'b0);
    send_code(8'h7F, 1'b0);
    send_code(TOK_RAW_LO, 1'b0);
    send_code(8'hFF, 1'b0);
    send_code(TOK_SPACE_LO, 1'b0);
    send_code(TOK_SPACE_HI, 1'b0);
    send_pair(11'd1, 3'd7, 1'b0);
    send_pair(11'd0, 3'd0, 1'b0);
    send_pair(11'd2047, 3'd7, 1'b0);
    send_code(TOK_RAW_HI, 1'b0);
    send_code(8'h00, 1'b0);
    send_code(8'h03, 1'b0);
    send_code(8'h88, 1'b0);
    // new record cuts the raw run short
    send_code(8'h41, 1'b1);
    send_code(8'h85, 1'b0);
    // and a half-received pair
    send_code(8'hC1, 1'b1);
    send_pair(11'd2, 3'd2, 1'b0);
    send_pair(11'd8, 3'd0, 1'b0);
  endtask

  task automatic test_size_limit();
    write_record_size(14'd1);
    send_code(8'h41, 1'b1);
    send_code(8'hC5, 1'b0);
    send_pair(11'd1, 3'd0, 1'b0);
    send_code(8'h02, 1'b0);
    send_code(8'h5A, 1'b0);
    send_code(8'hA5, 1'b0);
  endtask

  task automatic test_window_wrap();
    int unsigned tok;
    write_record_size(14'd8192);
    tok = 0;
    send_random_token(95, 1'b1, 1'b0, 1'b1);
    while (out_count < 14'd2100) begin
      if (tok % 40 == 0) begin
        gaps_on = 1'($urandom);
        stalls_on = 1'($urandom);
      end
      send_random_token(95, 1'b1, 1'b0, 1'b0);
      tok++;
    end
    send_pair(11'd2047, 3'd7, 1'b0);
    repeat (10) send_random_token(60, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_random_records();
    int unsigned base_cnt;
    int unsigned n;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_record_size(COUNT_W'($urandom_range(2, 12)));
        1: write_record_size(COUNT_W'($urandom_range(13, 80)));
        2: write_record_size(COUNT_W'($urandom_range(1, 8192)));
        default: write_record_size(RECORD_SIZE_RST);
      endcase
      base_cnt = sent_cnt;
      while (sent_cnt - base_cnt < 15) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        n = $urandom_range(2, 20);
        send_random_token(40, 1'b0, 1'b1, 1'b1);
        repeat (n - 1) send_random_token(40, 1'b0, 1'b1, 1'b0);
      end
    end
  endtask

  // result side: stall, then take and check one result at a time
  initial begin : result_side
    pdlz_out_t want;
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      out_ready = (hold == 0);
      if (hold > 0) begin
        hold--;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with nothing pending",
                                    out_data.out_byte));
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            report_mismatch($sformatf("out_byte expected 0x%02h got 0x%02h",
                                      want.out_byte, out_data.out_byte));
          end
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, out_data.status));
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run expected %0b got %0b",
                                      want.last_of_run, out_data.last_of_run));
          end
        end
        hold = stalls_on ? $urandom_range(0, 15) : 0;
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_size_limit();
    test_window_wrap();
    test_random_records();
    wait_all_results();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
